// ===== hdl/kib_pkg.sv =====
`default_nettype none

package kib_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_KMER_DFLT = 8;
  localparam int unsigned POS_BITS_DFLT = 24;
  localparam int unsigned QUEUE_DEPTH_DFLT = 4;

  // Fixed field widths of the channels.
  localparam int unsigned KMER_LEN_W = 4;
  localparam int unsigned KEY_OUT_W = 16;
  localparam int unsigned SLOT_W = 17;
  localparam int unsigned START_OUT_W = 24;

  localparam logic [KMER_LEN_W-1:0] KMER_LEN_RST = 4'd8;
  localparam logic [KMER_LEN_W-1:0] KMER_LEN_MIN = 4'd2;

  typedef enum logic {
    OP_BASE    = 1'b0,
    OP_NEW_REF = 1'b1
  } op_t;

  typedef logic [KMER_LEN_W-1:0] cfg_word_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] base;
    logic       strand;
    logic       first_base;
  } in_item_t;

  typedef struct packed {
    logic                   kmer_valid;
    logic [KEY_OUT_W-1:0]   kmer_key;
    logic [SLOT_W-1:0]      slot_id;
    logic                   is_new_slot;
    logic [START_OUT_W-1:0] kmer_start;
  } out_item_t;

  // One table entry: a valid mark and the slot number.
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } tbl_entry_t;

  // Queue entry at the default parameter values; the top level builds its own.
  typedef struct packed {
    op_t                        op;
    logic                       kmer_valid;
    logic                       strand;
    logic [2*MAX_KMER_DFLT-1:0] key;
    logic [POS_BITS_DFLT-1:0]   start;
  } qent_t;

endpackage

`default_nettype wire

// ===== hdl/kib_stream_if.sv =====
`default_nettype none

interface kib_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/kib_front.sv =====
`default_nettype none

module kib_front #(
  parameter int unsigned MAX_KMER = kib_pkg::MAX_KMER_DFLT,
  parameter int unsigned POS_BITS = kib_pkg::POS_BITS_DFLT,
  parameter type qent_t = kib_pkg::qent_t
) (
  input  logic         clk,
  input  logic         rst_n,
  kib_stream_if.sink   in_ch,
  kib_stream_if.sink   cfg_ch,
  input  logic         q_full,
  input  logic         clr_busy,
  output logic         q_push,
  output qent_t        q_data
);

  localparam int unsigned KEY_W = 2 * MAX_KMER;
  localparam int unsigned KLEN_W = kib_pkg::KMER_LEN_W;

  logic [KLEN_W-1:0]   kmer_len_r;
  logic [KLEN_W-1:0]   klen_eff;
  logic [KEY_W-1:0]    window_r;
  logic [KEY_W-1:0]    window_nxt;
  logic [KEY_W-1:0]    win_base;
  logic [KEY_W-1:0]    key_mask;
  logic [POS_BITS-1:0] seen_r;
  logic [POS_BITS-1:0] seen_nxt;
  logic [POS_BITS-1:0] seen_base;
  logic                in_fire;
  logic                full_win;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full && !clr_busy;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (kmer_len_r < kib_pkg::KMER_LEN_MIN) begin
      klen_eff = kib_pkg::KMER_LEN_MIN;
    end else if (kmer_len_r > KLEN_W'(MAX_KMER)) begin
      klen_eff = KLEN_W'(MAX_KMER);
    end else begin
      klen_eff = kmer_len_r;
    end
  end

  // A first base restarts the window and the position count.
  assign win_base   = in_ch.data.first_base ? '0 : window_r;
  assign seen_base  = in_ch.data.first_base ? '0 : seen_r;
  assign window_nxt = {win_base[KEY_W-3:0], in_ch.data.base};
  assign seen_nxt   = (seen_base == '1) ? seen_base : seen_base + POS_BITS'(1);
  assign full_win   = seen_nxt >= POS_BITS'(klen_eff);

  always_comb begin
    for (int i = 0; i < MAX_KMER; i++) begin
      key_mask[2*i +: 2] = (KLEN_W'(i) < klen_eff) ? 2'b11 : 2'b00;
    end
  end

  always_comb begin
    q_data            = '0;
    q_data.op         = in_ch.data.op;
    q_data.strand     = in_ch.data.strand;
    q_data.kmer_valid = full_win;
    if (full_win) begin
      q_data.key   = window_nxt & key_mask;
      q_data.start = seen_nxt - POS_BITS'(klen_eff);
    end
  end

  assign q_push = in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= kib_pkg::KMER_LEN_RST;
      window_r   <= '0;
      seen_r     <= '0;
    end else begin
      if (cfg_ch.valid) begin
        kmer_len_r <= cfg_ch.data;
      end
      if (in_fire) begin
        if (in_ch.data.op == kib_pkg::OP_NEW_REF) begin
          window_r <= '0;
          seen_r   <= '0;
        end else begin
          window_r <= window_nxt;
          seen_r   <= seen_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/kib_queue.sv =====
`default_nettype none

module kib_queue #(
  parameter int unsigned DEPTH = kib_pkg::QUEUE_DEPTH_DFLT,
  parameter type qent_t = kib_pkg::qent_t
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qent_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign head  = entries[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== hdl/kib_back.sv =====
`default_nettype none

module kib_back #(
  parameter int unsigned MAX_KMER = kib_pkg::MAX_KMER_DFLT,
  parameter type qent_t = kib_pkg::qent_t
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  qent_t        q_head,
  output logic         q_pop,
  output logic         clr_busy,
  kib_stream_if.source out_ch
);

  localparam int unsigned KEY_W = 2 * MAX_KMER;
  localparam int unsigned ADDR_W = KEY_W + 1;
  localparam int unsigned TBL_DEPTH = 2 ** ADDR_W;
  localparam int unsigned SLOT_W = kib_pkg::SLOT_W;
  localparam int unsigned KEY_OUT_W = kib_pkg::KEY_OUT_W;
  localparam int unsigned START_OUT_W = kib_pkg::START_OUT_W;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  // Both strand tables in one memory; the strand bit is the top address bit.
  kib_pkg::tbl_entry_t tbl [TBL_DEPTH];

  state_t              state_r;
  logic [ADDR_W-1:0]   clr_addr_r;
  logic [SLOT_W-1:0]   next_slot_r;
  logic                s2_valid_r;
  qent_t               s2_r;
  kib_pkg::tbl_entry_t s2_ent_r;
  logic                out_valid_r;
  kib_pkg::out_item_t  out_r;

  logic                head_base;
  logic                clr_start;
  logic                s2_adv;
  logic                s2_load;
  logic                s2_new;
  logic [SLOT_W-1:0]   s2_slot;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  kib_pkg::tbl_entry_t wr_data;
  logic [ADDR_W-1:0]   rd_addr;

  assign clr_busy  = state_r == ST_CLEAR;
  assign head_base = !q_empty && q_head.op == kib_pkg::OP_BASE;
  assign s2_adv    = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign s2_load   = state_r == ST_RUN && head_base && (!s2_valid_r || s2_adv);
  assign clr_start = state_r == ST_RUN && !q_empty && q_head.op == kib_pkg::OP_NEW_REF
                     && !s2_valid_r;
  assign q_pop     = s2_load || clr_start;

  assign s2_new  = s2_r.kmer_valid && !s2_ent_r.valid;
  assign s2_slot = s2_ent_r.valid ? s2_ent_r.slot : next_slot_r;

  assign rd_addr = {q_head.strand, q_head.key};

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else begin
      wr_en         = s2_adv && s2_new;
      wr_addr       = {s2_r.strand, s2_r.key};
      wr_data.valid = 1'b1;
      wr_data.slot  = next_slot_r;
    end
  end

  // The read that loads the next item sees a write of the same edge through the bypass.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl[wr_addr] <= wr_data;
    end
    if (s2_load) begin
      s2_r     <= q_head;
      s2_ent_r <= (wr_en && wr_addr == rd_addr) ? wr_data : tbl[rd_addr];
    end
    if (s2_adv) begin
      out_r.kmer_valid  <= s2_r.kmer_valid;
      out_r.kmer_key    <= KEY_OUT_W'(s2_r.key);
      out_r.slot_id     <= s2_r.kmer_valid ? s2_slot : '0;
      out_r.is_new_slot <= s2_new;
      out_r.kmer_start  <= START_OUT_W'(s2_r.start);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      next_slot_r <= '0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == '1) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (clr_start) begin
            state_r     <= ST_CLEAR;
            clr_addr_r  <= '0;
            next_slot_r <= '0;
          end else if (s2_adv && s2_new) begin
            next_slot_r <= next_slot_r + SLOT_W'(1);
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_no_load_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == ST_CLEAR && (s2_load || s2_valid_r)))
    else $error("table lookup while clearing");
  a_clear_follows: assert property (@(posedge clk) disable iff (!rst_n)
    clr_start |=> state_r == ST_CLEAR && next_slot_r == '0)
    else $error("new reference did not start a clearing pass");
  a_new_has_kmer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.is_new_slot |-> out_r.kmer_valid)
    else $error("new slot reported without a full window");

endmodule

`default_nettype wire

// ===== hdl/kmer_index_builder_unit.sv =====
`default_nettype none

// Rolling k-mer index builder. Each base transfer on in_ch shifts a 2-bit code into a
// window; once kmer_len bases of the current strand sequence are in, the k-mer is
// looked up in that strand's table and gets its slot (a fresh one from the shared
// counter on first sighting). Every base yields exactly one transfer on out_ch; a
// new-reference transfer yields none. Throughput is one base per clock while out_ch
// is ready and no clearing pass runs: the front end updates the window and the back
// end does one table read-modify-write per cycle. While a result waits on out_ch,
// the queue absorbs up to QUEUE_DEPTH further bases before in_ch.ready drops.
// From input to output a base is registered in the queue, the table stage and the
// output register. The tables are one single-port-write, single-port-read memory of
// 2^(2*MAX_KMER+1) entries. After reset, and for each new-reference transfer, a
// clearing pass writes every entry, one per cycle; in_ch.ready stays low during it.
// cfg_ch is always ready and should only be written while the block is idle.

module kmer_index_builder_unit #(
  parameter int unsigned MAX_KMER    = kib_pkg::MAX_KMER_DFLT,
  parameter int unsigned POS_BITS    = kib_pkg::POS_BITS_DFLT,
  parameter int unsigned QUEUE_DEPTH = kib_pkg::QUEUE_DEPTH_DFLT
) (
  input  logic         clk,
  input  logic         rst_n,
  kib_stream_if.sink   in_ch,
  kib_stream_if.source out_ch,
  kib_stream_if.sink   cfg_ch
);

  // Classified base as it travels from the front end to the table stage.
  typedef struct packed {
    kib_pkg::op_t          op;
    logic                  kmer_valid;
    logic                  strand;
    logic [2*MAX_KMER-1:0] key;
    logic [POS_BITS-1:0]   start;
  } queue_ent_t;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  logic       clr_busy;
  queue_ent_t q_in;
  queue_ent_t q_head;

  // The front end owns the window, position count and the kmer_len register.
  kib_front #(
    .MAX_KMER (MAX_KMER),
    .POS_BITS (POS_BITS),
    .qent_t   (queue_ent_t)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_full   (q_full),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // The queue lets the front end keep taking bases while the output is stalled.
  kib_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .qent_t (queue_ent_t)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // The back end does the table lookup, slot assignment and clearing passes.
  kib_back #(
    .MAX_KMER (MAX_KMER),
    .qent_t   (queue_ent_t)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .clr_busy (clr_busy),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/kmer_index_builder_unit_test.sv =====
`timescale 1ns / 100ps

module kmer_index_builder_unit_test;

  // The block clears its tables after reset and for every new-reference transfer,
  // one entry per cycle. The watchdog limit allows about three passes in a row
  // without any transfer before it gives up.
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  // Time for the pipeline to settle. This is used before a register write and
  // at the very end of the run.
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned KEY_W = 2 * kib_pkg::MAX_KMER_DFLT;
  localparam int unsigned TBL_DEPTH = 1 << KEY_W;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kib_stream_if #(.payload_t(kib_pkg::in_item_t))  in_ch ();
  kib_stream_if #(.payload_t(kib_pkg::out_item_t)) out_ch ();
  kib_stream_if #(.payload_t(kib_pkg::cfg_word_t)) cfg_ch ();

  kmer_index_builder_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // The predictor keeps its own copy of the index. It holds one table per strand,
  // and each entry is a seen mark plus the slot number that the entry was given.
  kib_pkg::tbl_entry_t kmer_tbl [2][TBL_DEPTH];
  logic [KEY_W-1:0]    win_key;
  logic [23:0]         seq_len;
  logic [17:0]         slot_ctr;
  kib_pkg::cfg_word_t  len_reg;

  kib_pkg::in_item_t  pending_bases [$];
  kib_pkg::out_item_t expected_hits [$];

  // The driver sets this flag while it holds an item that has not been
  // transferred yet. Only the driver writes it, and it writes it with blocking
  // assignments. The main sequence therefore never reads a stale idle state at
  // the edge on which the driver pops an item.
  bit holding = 1'b0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned rx_hold = 0;
  bit pressure_done = 1'b0;

  int unsigned errors = 0;
  int unsigned bases_fed = 0;
  int unsigned results_seen = 0;
  int unsigned windows_seen = 0;
  int unsigned fresh_slots = 0;
  int unsigned repeat_hits = 0;
  int unsigned new_refs = 0;
  int unsigned cfg_writes = 0;
  int unsigned idle_cycles = 0;

  // The state of the random sequence survives from one phase to the next. A new
  // k-mer length can therefore take effect in the middle of a strand sequence.
  int unsigned seq_left = 0;
  bit          cur_strand = 1'b0;
  bit          narrow_alpha = 1'b0;

  function automatic void clear_index();
    foreach (kmer_tbl[s, e]) kmer_tbl[s][e] = '0;
    win_key = '0;
    seq_len = '0;
    slot_ctr = '0;
  endfunction

  // This works out the result of one accepted item. It queues nothing for a new
  // reference, and it queues one result for every base.
  function automatic void index_base(kib_pkg::in_item_t item);
    int unsigned k;
    logic [31:0] mask;
    logic [KEY_W-1:0] key;
    kib_pkg::out_item_t res;
    if (item.op == kib_pkg::OP_NEW_REF) begin
      clear_index();
      return;
    end
    if (item.first_base) begin
      win_key = '0;
      seq_len = '0;
    end
    win_key = {win_key[KEY_W-3:0], item.base};
    if (seq_len != '1) seq_len = seq_len + 24'd1;
    // Lengths outside the legal range are clamped to the nearest legal value.
    if (len_reg < kib_pkg::KMER_LEN_MIN) k = 32'(kib_pkg::KMER_LEN_MIN);
    else if (len_reg > kib_pkg::MAX_KMER_DFLT) k = kib_pkg::MAX_KMER_DFLT;
    else k = 32'(len_reg);
    res = '0;
    if (seq_len >= k) begin
      mask = (32'd1 << (2 * k)) - 32'd1;
      key = win_key & mask[KEY_W-1:0];
      res.kmer_valid = 1'b1;
      res.kmer_key = key;
      if (kmer_tbl[item.strand][key].valid) begin
        res.slot_id = kmer_tbl[item.strand][key].slot;
        res.is_new_slot = 1'b0;
      end else begin
        // Both strands draw from the same slot counter.
        res.slot_id = slot_ctr[kib_pkg::SLOT_W-1:0];
        kmer_tbl[item.strand][key].valid = 1'b1;
        kmer_tbl[item.strand][key].slot = slot_ctr[kib_pkg::SLOT_W-1:0];
        slot_ctr = slot_ctr + 18'd1;
        res.is_new_slot = 1'b1;
      end
      res.kmer_start = seq_len - k[23:0];
    end
    expected_hits.insert(expected_hits.size(), res);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val,
                                      logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h",
               $time, name, exp_val, got_val);
      errors++;
    end
  endfunction

  // The driver offers the items of the pending queue one after another. After
  // each transfer it draws a gap of idle cycles, unless the phase runs in burst
  // mode.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        index_base(in_ch.data);
        if (in_ch.data.op == kib_pkg::OP_NEW_REF) new_refs++;
        else bases_fed++;
        holding = 1'b0;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
      end
      if (!holding) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_bases.size() > 0) begin
          in_ch.data <= pending_bases.pop_front();
          holding = 1'b1;
        end
        in_ch.valid <= holding;
      end
    end
  end

  // The monitor checks every result transfer against the oldest expectation. It
  // also throttles out_ch.ready. Once in the run it holds ready low for a long
  // stretch, so that the internal queue fills up and the block stalls in_ch.
  always @(posedge clk) begin
    kib_pkg::out_item_t exp_res;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_hits.size() == 0) begin
          $display("%0t: result with nothing expected, actual %p", $time, out_ch.data);
          errors++;
        end else begin
          exp_res = expected_hits.pop_front();
          check_field("kmer_valid", 32'(exp_res.kmer_valid),
                      32'(out_ch.data.kmer_valid));
          check_field("kmer_key", 32'(exp_res.kmer_key), 32'(out_ch.data.kmer_key));
          check_field("slot_id", 32'(exp_res.slot_id), 32'(out_ch.data.slot_id));
          check_field("is_new_slot", 32'(exp_res.is_new_slot),
                      32'(out_ch.data.is_new_slot));
          check_field("kmer_start", 32'(exp_res.kmer_start),
                      32'(out_ch.data.kmer_start));
          if (exp_res.kmer_valid) begin
            windows_seen++;
            if (exp_res.is_new_slot) fresh_slots++;
            else repeat_hits++;
          end
        end
        rx_gap = rx_burst ? 0 : $urandom_range(0, 10);
        if (!pressure_done && results_seen == 150) begin
          rx_hold = 80;
          pressure_done = 1'b1;
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // The watchdog counts cycles in which no transfer happens on either stream.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_base(logic [1:0] b, bit s, bit first);
    kib_pkg::in_item_t item;
    item = '0;
    item.op = kib_pkg::OP_BASE;
    item.base = b;
    item.strand = s;
    item.first_base = first;
    pending_bases.insert(pending_bases.size(), item);
  endtask

  task automatic push_new_ref();
    kib_pkg::in_item_t item;
    item = '0;
    item.op = kib_pkg::OP_NEW_REF;
    // The other fields carry random values. The block has to ignore them here.
    item.base = 2'($urandom_range(0, 3));
    item.strand = 1'($urandom_range(0, 1));
    item.first_base = 1'($urandom_range(0, 1));
    pending_bases.insert(pending_bases.size(), item);
  endtask

  // This waits until all items have gone in and every expected result has come
  // out. It then lets the pipeline settle and waits out any clearing pass.
  task automatic wait_idle();
    while (pending_bases.size() > 0 || holding || expected_hits.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_kmer_len(kib_pkg::cfg_word_t v);
    @(posedge clk);
    cfg_ch.data <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    len_reg = v;
    cfg_writes++;
  endtask

  // This builds one phase of random items. Most of them form well-formed strand
  // sequences. Each sequence opens with a first-base mark and then keeps its
  // strand. A narrow alphabet of A and C makes repeated k-mers common. A small
  // share of items flips the strand or restarts the window at random, and this
  // acts as noise.
  task automatic gen_phase(int unsigned n, bit with_new_ref);
    int unsigned roll;
    bit first;
    logic [1:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      first = 1'b0;
      if (seq_left == 0) begin
        first = 1'b1;
        seq_left = $urandom_range(1, 40);
        cur_strand = 1'($urandom_range(0, 1));
        narrow_alpha = ($urandom_range(0, 2) == 0);
      end
      seq_left--;
      roll = $urandom_range(0, 99);
      if (roll < 4) cur_strand = ~cur_strand;
      if (roll >= 96) first = 1'b1;
      b = narrow_alpha ? 2'($urandom_range(0, 1)) : 2'($urandom_range(0, 3));
      push_base(b, cur_strand, first);
      if (with_new_ref && i == n / 2) push_new_ref();
    end
  endtask

  initial begin
    kib_pkg::cfg_word_t settings [12];
    settings = '{4'd15, 4'd2, 4'd5, 4'd1, 4'd8, 4'd3,
                 4'd9, 4'd6, 4'd4, 4'd7, 4'd12, 4'd8};
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    clear_index();
    len_reg = kib_pkg::KMER_LEN_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, at the reset length of 8. A forward run of T reaches the
    // all-ones key and then repeats it. The same key on the reverse strand, with
    // no first-base mark, gets its own slot from the shared counter. After a new
    // reference, an all-A reverse sequence gives the all-zero key, and one more
    // base switches to the forward table in mid-sequence.
    push_base(2'd3, 1'b0, 1'b1);
    repeat (8) push_base(2'd3, 1'b0, 1'b0);
    repeat (2) push_base(2'd3, 1'b1, 1'b0);
    push_new_ref();
    push_base(2'd0, 1'b1, 1'b1);
    repeat (7) push_base(2'd0, 1'b1, 1'b0);
    push_base(2'd0, 1'b0, 1'b0);
    wait_idle();

    // A length of zero is below the legal range and acts as 2. The window is
    // not restarted, so the new length applies to the bases already held.
    write_kmer_len(4'd0);
    push_base(2'd2, 1'b0, 1'b0);
    push_base(2'd1, 1'b0, 1'b0);
    push_base(2'd2, 1'b0, 1'b0);
    push_base(2'd1, 1'b0, 1'b0);
    wait_idle();

    // Random part. It runs through a list of lengths that covers both extremes
    // and values outside the range. Each phase has its own idle pattern, and
    // some phases run in burst mode with no idling on one side or on both.
    foreach (settings[ph]) begin
      write_kmer_len(settings[ph]);
      tx_burst = (ph % 4 == 1);
      rx_burst = (ph % 4 == 1) || (ph % 4 == 3);
      gen_phase(34, ph == 3 || ph == 8);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Fed %0d bases and %0d new references under %0d length settings.",
             bases_fed, new_refs, cfg_writes);
    $display("Checked %0d results: %0d full windows, %0d new slots, %0d repeats.",
             results_seen, windows_seen, fresh_slots, repeat_hits);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
